// ----- rtl/rhd_pkg.sv -----
`default_nettype none

package rhd_pkg;

	// channel and datapath widths
	localparam int CH_W    = 8;             // one colour channel, also the hue
	localparam int M_W     = 11;            // sector position, below 6*delta
	localparam int NUM_W   = 17;            // 85*M
	localparam int DEN_W   = 9;             // 2*delta
	localparam int SM_W    = 12;            // signed sector position before wrap
	localparam int REF_W   = 3 * CH_W;      // packed reference colour

	localparam int HUE_SCALE = 85;

	// restoring division: quotient bits resolved per stage
	localparam int DIV_BITS_PER_STAGE = 2;
	localparam int DIV_STAGES         = CH_W / DIV_BITS_PER_STAGE;

	// hue pipeline: sector stage, scale stage, divider stages, rounding stage
	localparam int DIV_FIRST   = 2;
	localparam int LANE_STAGES = DIV_FIRST + DIV_STAGES + 1;
	localparam int PIPE_STAGES = LANE_STAGES + 1;

	typedef struct packed {
		logic [LANE_STAGES-1:0] adv;
	} pipe_ctrl_t;

endpackage

`default_nettype wire

// ----- rtl/rhd_hue_pipe.sv -----
`default_nettype none

module rhd_hue_pipe import rhd_pkg::*; (
	input  logic            clk,
	input  pipe_ctrl_t      ctrl,
	input  logic [CH_W-1:0] red,
	input  logic [CH_W-1:0] green,
	input  logic [CH_W-1:0] blue,
	output logic [CH_W-1:0] hue
);

	// stage 1: max, min, delta and position inside the hue circle
	logic [CH_W-1:0]        mx, mn, delta;
	logic signed [SM_W-1:0] d_sx, m_raw, m_wrap;
	logic                   gray;

	always_comb begin
		mx = red;
		mn = red;
		if (green > mx) mx = green;
		if (blue > mx)  mx = blue;
		if (green < mn) mn = green;
		if (blue < mn)  mn = blue;
		delta = mx - mn;
		gray  = (mx == mn);
		d_sx  = $signed({{(SM_W-CH_W){1'b0}}, delta});
		// red wins ties over green, green over blue
		if (mx == red)
			m_raw = $signed({{(SM_W-CH_W){1'b0}}, green})
				- $signed({{(SM_W-CH_W){1'b0}}, blue});
		else if (mx == green)
			m_raw = (d_sx <<< 1) + $signed({{(SM_W-CH_W){1'b0}}, blue})
				- $signed({{(SM_W-CH_W){1'b0}}, red});
		else
			m_raw = (d_sx <<< 2) + $signed({{(SM_W-CH_W){1'b0}}, red})
				- $signed({{(SM_W-CH_W){1'b0}}, green});
		m_wrap = (m_raw < 0) ? m_raw + (d_sx <<< 2) + (d_sx <<< 1) : m_raw;
	end

	logic [M_W-1:0]  m_s1;
	logic [CH_W-1:0] d_s1;
	logic            gray_s1;

	always_ff @(posedge clk) begin
		if (ctrl.adv[0]) begin
			m_s1    <= m_wrap[M_W-1:0];
			d_s1    <= delta;
			gray_s1 <= gray;
		end
	end

	// stage 2: numerator 85*M and denominator 2*delta
	logic [NUM_W-1:0] num_s2;
	logic [DEN_W-1:0] den_s2;
	logic             gray_s2;

	always_ff @(posedge clk) begin
		if (ctrl.adv[1]) begin
			num_s2  <= NUM_W'(m_s1) * NUM_W'(HUE_SCALE);
			den_s2  <= {d_s1, 1'b0};
			gray_s2 <= gray_s1;
		end
	end

	// divider stages: restoring division, a few quotient bits per stage
	logic [DEN_W-1:0] div_rem_s  [DIV_STAGES];
	logic [CH_W-1:0]  div_low_s  [DIV_STAGES];
	logic [CH_W-1:0]  div_quo_s  [DIV_STAGES];
	logic [DEN_W-1:0] div_den_s  [DIV_STAGES];
	logic             div_gray_s [DIV_STAGES];

	for (genvar j = 0; j < DIV_STAGES; j++) begin : g_div
		logic [DEN_W-1:0] rem_in, rem_nx;
		logic [CH_W-1:0]  low_in, low_nx, quo_in, quo_nx;
		logic [DEN_W-1:0] den_in;
		logic             gray_in;

		if (j == 0) begin : g_head
			// numerator high part is already below the denominator
			assign rem_in  = num_s2[NUM_W-1:CH_W];
			assign low_in  = num_s2[CH_W-1:0];
			assign quo_in  = '0;
			assign den_in  = den_s2;
			assign gray_in = gray_s2;
		end else begin : g_body
			assign rem_in  = div_rem_s[j-1];
			assign low_in  = div_low_s[j-1];
			assign quo_in  = div_quo_s[j-1];
			assign den_in  = div_den_s[j-1];
			assign gray_in = div_gray_s[j-1];
		end

		always_comb begin
			logic [DEN_W:0] cur;
			rem_nx = rem_in;
			low_nx = low_in;
			quo_nx = quo_in;
			for (int t = 0; t < DIV_BITS_PER_STAGE; t++) begin
				cur    = {rem_nx, low_nx[CH_W-1]};
				low_nx = {low_nx[CH_W-2:0], 1'b0};
				if (cur >= {1'b0, den_in}) begin
					rem_nx = DEN_W'(cur - {1'b0, den_in});
					quo_nx = {quo_nx[CH_W-2:0], 1'b1};
				end else begin
					rem_nx = cur[DEN_W-1:0];
					quo_nx = {quo_nx[CH_W-2:0], 1'b0};
				end
			end
		end

		always_ff @(posedge clk) begin
			if (ctrl.adv[DIV_FIRST+j]) begin
				div_rem_s[j]  <= rem_nx;
				div_low_s[j]  <= low_nx;
				div_quo_s[j]  <= quo_nx;
				div_den_s[j]  <= den_in;
				div_gray_s[j] <= gray_in;
			end
		end
	end

	// rounding stage: half to even, gray forces zero
	logic [DEN_W:0]  rem_x2;
	logic            round_up;
	logic [CH_W-1:0] hue_s7;

	always_comb begin
		rem_x2   = {div_rem_s[DIV_STAGES-1], 1'b0};
		round_up = (rem_x2 > {1'b0, div_den_s[DIV_STAGES-1]})
			|| ((rem_x2 == {1'b0, div_den_s[DIV_STAGES-1]})
				&& div_quo_s[DIV_STAGES-1][0]);
	end

	always_ff @(posedge clk) begin
		if (ctrl.adv[LANE_STAGES-1]) begin
			if (div_gray_s[DIV_STAGES-1])
				hue_s7 <= '0;
			else
				hue_s7 <= div_quo_s[DIV_STAGES-1] + CH_W'(round_up);
		end
	end

	assign hue = hue_s7;

endmodule

`default_nettype wire

// ----- rtl/rgb_hue_distance.sv -----
// Throughput: one request per cycle while out_ready is high; every stage
// holds its own valid bit, so empty stages keep filling while the output
// waits.
// Reset (arst_n low, asynchronous): clears all valid bits and the reference
// colour to zero; datapath registers are not reset.
`default_nettype none

module rgb_hue_distance import rhd_pkg::*; (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             cfg_write,
	input  logic [REF_W-1:0] cfg_data,
	input  logic             in_valid,
	output logic             in_ready,
	input  logic [CH_W-1:0]  pixel_red,
	input  logic [CH_W-1:0]  pixel_green,
	input  logic [CH_W-1:0]  pixel_blue,
	output logic             out_valid,
	input  logic             out_ready,
	output logic [CH_W-1:0]  hue_distance
);

	// Reference colour register: red 23:16, green 15:8, blue 7:0.
	logic [REF_W-1:0] ref_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ref_q <= '0;
		end else if (cfg_write) begin
			ref_q <= cfg_data;
		end
	end

	// Pipeline control. A stage advances when it is empty or when the stage
	// after it advances; the last stage advances when the output is taken.
	logic [PIPE_STAGES-1:0] vld_q;
	logic [PIPE_STAGES-1:0] adv;
	pipe_ctrl_t             ctrl;

	always_comb begin
		adv[PIPE_STAGES-1] = !vld_q[PIPE_STAGES-1] || out_ready;
		for (int k = PIPE_STAGES - 2; k >= 0; k--)
			adv[k] = !vld_q[k] || adv[k+1];
	end

	assign ctrl.adv = adv[LANE_STAGES-1:0];
	assign in_ready = adv[0];

	// Move each valid bit along with its stage; a held stage keeps its bit.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= '0;
		end else begin
			if (adv[0])
				vld_q[0] <= in_valid;
			for (int k = 1; k < PIPE_STAGES; k++)
				if (adv[k])
					vld_q[k] <= vld_q[k-1];
		end
	end

	// Two identical hue lanes share the stage enables: one for the pixel,
	// one for the reference colour. The user must change the reference only
	// while idle, unenforced; recomputing it per pixel gives the same answer.
	logic [CH_W-1:0] pix_hue, ref_hue;

	rhd_hue_pipe u_pix_hue (
		.clk   (clk),
		.ctrl  (ctrl),
		.red   (pixel_red),
		.green (pixel_green),
		.blue  (pixel_blue),
		.hue   (pix_hue)
	);

	rhd_hue_pipe u_ref_hue (
		.clk   (clk),
		.ctrl  (ctrl),
		.red   (ref_q[3*CH_W-1:2*CH_W]),
		.green (ref_q[2*CH_W-1:CH_W]),
		.blue  (ref_q[CH_W-1:0]),
		.hue   (ref_hue)
	);

	// Output stage: absolute hue difference, held until taken.
	logic [CH_W-1:0] dist_s8;

	always_ff @(posedge clk) begin
		if (adv[PIPE_STAGES-1]) begin
			if (ref_hue > pix_hue)
				dist_s8 <= ref_hue - pix_hue;
			else
				dist_s8 <= pix_hue - ref_hue;
		end
	end

	assign out_valid    = vld_q[PIPE_STAGES-1];
	assign hue_distance = dist_s8;

endmodule

`default_nettype wire

// ----- rtl/rhd_checker.sv -----
`default_nettype none

module rhd_checker import rhd_pkg::*; (
	input logic            clk,
	input logic            arst_n,
	input logic            in_ready,
	input logic            out_valid,
	input logic            out_ready,
	input logic [CH_W-1:0] hue_distance
);

	// a waiting result stays
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid)
		else $error("result dropped while stalled");

	a_out_stable: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> $stable(hue_distance))
		else $error("result changed while stalled");

	// a draining output lets every stage advance
	a_ready_follow: assert property (@(posedge clk) disable iff (!arst_n)
		out_ready |-> in_ready)
		else $error("input blocked while output drains");

	// an empty output stage cannot block the input
	a_ready_empty: assert property (@(posedge clk) disable iff (!arst_n)
		!out_valid |-> in_ready)
		else $error("input blocked with empty output");

endmodule

bind rgb_hue_distance rhd_checker u_rhd_checker (
	.clk          (clk),
	.arst_n       (arst_n),
	.in_ready     (in_ready),
	.out_valid    (out_valid),
	.out_ready    (out_ready),
	.hue_distance (hue_distance)
);

`default_nettype wire
